/* design/adc_to_temperature_table_interp_unit_assert.svh */
// assertion macros for the temperature conversion unit
`ifndef ADC_TO_TEMPERATURE_TABLE_INTERP_UNIT_ASSERT_SVH
`define ADC_TO_TEMPERATURE_TABLE_INTERP_UNIT_ASSERT_SVH

// same-cycle implication
`define ATTU_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication
`define ATTU_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("assertion failed");

// implication after a fixed delay
`define ATTU_ASSERT_DELAY(label, ante, n, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##n (cons)) \
      else $error("assertion failed");

`endif

/* design/attu_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package attu_pkg;

   localparam int TABLE_DEPTH  = 64;
   localparam int ADDR_W       = $clog2(TABLE_DEPTH);
   localparam int SEARCH_STEPS = ADDR_W;

   localparam int ADC_W  = 10;
   localparam int IDX_W  = 6;
   localparam int TE_W   = 7;
   localparam int DEG_W  = 6;
   localparam int AMB_W  = 8;
   localparam int TEMP_W = 13;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;

   localparam int NUM_W     = ADC_W + DEG_W;
   localparam int DIV_STEPS = NUM_W;
   localparam int IDD_W     = ADDR_W + DEG_W;
   localparam int SUM_W     = NUM_W + 3;
   localparam int LATENCY   = 2 * SEARCH_STEPS + DIV_STEPS + 4;

   localparam int TEMP_MIN = -2048;
   localparam int TEMP_MAX = 4095;

   localparam logic [TE_W-1:0]  TE_RESET  = TE_W'(64);
   localparam logic [DEG_W-1:0] DEG_RESET = DEG_W'(10);
   localparam logic [AMB_W-1:0] AMB_RESET = AMB_W'(25);
   localparam logic [ADC_W-1:0] THR_RESET = ADC_W'(850);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TABLE_ENTRIES = 3'd0,
      CSR_DEGREES       = 3'd1,
      CSR_AMBIENT       = 3'd2,
      CSR_THRESHOLD     = 3'd3
   } csr_index_type;

   typedef struct packed {
      logic              valid;
      logic              wr;
      logic              wok;
      logic              conn;
      logic [ADC_W-1:0]  v;
      logic [ADDR_W-1:0] widx;
      logic [ADC_W-1:0]  wval;
      logic [ADDR_W-1:0] lo;
      logic [ADDR_W-1:0] hi;
      logic [ADC_W-1:0]  vlo;
      logic [ADC_W-1:0]  vhi;
      logic              done;
      logic [ADDR_W-1:0] pick;
      logic              mid_pend;
      logic [ADDR_W-1:0] mid;
   } search_type;

   typedef struct packed {
      logic             valid;
      logic             conn;
      logic             direct;
      logic             neg;
      logic [IDD_W-1:0] idd;
      logic [NUM_W-1:0] num;
      logic [ADC_W-1:0] den;
      logic [ADC_W-1:0] rem;
      logic [NUM_W-1:0] quo;
   } arith_type;

endpackage
`default_nettype wire

/* design/adc_to_temperature_table_interp_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// thermocouple reading to temperature by table search and interpolation
// input transaction: start high while busy is low; req_mode 1 writes table
//   entry req_entry_index with req_entry_value, req_mode 0 converts
//   req_adc_reading
// result transaction: rsp_valid high for one cycle with rsp_connected and
//   rsp_temperature; one result per convert, none per table write
// csr channel: csr_valid/csr_ready (always high) with csr_index and csr_data;
//   the user writes only with no conversion in flight; the block does not check
// a new transaction every cycle while busy is low; the binary search runs
//   six steps, each step holding in sb_ff while it reads its own copy of
//   the table, then taking its compare into sa_ff; the divide is sixteen
//   stages of one quotient bit each
// table writes travel down the pipe and update each table copy as they pass,
//   so conversions see exactly the writes accepted before them
// reset clears the pipe and loads the default csr values; busy is high for
//   the cycle after reset; the table holds nothing valid until written
// the receiver cannot stall, so the pipe never holds back
module adc_to_temperature_table_interp_unit
   import attu_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   output logic                    busy,
   input  logic                    req_mode,
   input  logic [ADC_W-1:0]        req_adc_reading,
   input  logic [IDX_W-1:0]        req_entry_index,
   input  logic [ADC_W-1:0]        req_entry_value,
   output logic                    rsp_valid,
   output logic                    rsp_connected,
   output logic signed [TEMP_W-1:0] rsp_temperature,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_data
);

   logic [TE_W-1:0]         te_ff;
   logic [DEG_W-1:0]        deg_ff;
   logic signed [AMB_W-1:0] amb_ff;
   logic [ADC_W-1:0]        thr_ff;
   logic                    busy_ff;

   logic [ADDR_W:0]   n_eff;
   logic [ADDR_W-1:0] n_last;

   search_type sa_ff [SEARCH_STEPS+1];
   search_type sb_ff [SEARCH_STEPS];
   search_type sa_cur [SEARCH_STEPS+1];
   search_type sa_in;

   logic [ADC_W-1:0] rd_first;
   logic [ADC_W-1:0] rd_last;
   logic [ADC_W-1:0] step_rd [SEARCH_STEPS];
   logic [ADC_W-1:0] rd_a0;
   logic [ADC_W-1:0] rd_a1;

   logic              fin_valid_ff;
   logic              fin_conn_ff;
   logic [ADC_W-1:0]  fin_v_ff;
   logic [ADDR_W-1:0] fin_pick_ff;
   logic              fin_last_ff;
   logic [ADDR_W-1:0] fin_pick_in;

   arith_type m_in;
   arith_type m_ff;
   arith_type div_ff [DIV_STEPS];
   arith_type div_in [DIV_STEPS];

   logic                     out_valid_ff;
   logic                     out_conn_ff;
   logic signed [TEMP_W-1:0] out_temp_ff;
   logic signed [TEMP_W-1:0] out_temp_in;

   logic wr_now;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         te_ff   <= TE_RESET;
         deg_ff  <= DEG_RESET;
         amb_ff  <= AMB_RESET;
         thr_ff  <= THR_RESET;
         busy_ff <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_valid) begin
            case (csr_index)
               CSR_TABLE_ENTRIES: te_ff  <= csr_data[TE_W-1:0];
               CSR_DEGREES:       deg_ff <= csr_data[DEG_W-1:0];
               CSR_AMBIENT:       amb_ff <= csr_data[AMB_W-1:0];
               CSR_THRESHOLD:     thr_ff <= csr_data[ADC_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = busy_ff;

   always_comb begin
      if (int'(te_ff) < 2) begin
         n_eff = (ADDR_W+1)'(2);
      end else if (int'(te_ff) > TABLE_DEPTH) begin
         n_eff = (ADDR_W+1)'(TABLE_DEPTH);
      end else begin
         n_eff = (ADDR_W+1)'(te_ff);
      end
      n_last = ADDR_W'(n_eff - (ADDR_W+1)'(1));
   end

   // entry
   assign wr_now = start && !busy_ff && req_mode && (int'(req_entry_index) < TABLE_DEPTH);

   always_comb begin
      sa_in          = '0;
      sa_in.valid    = start && !busy_ff;
      sa_in.wr       = req_mode;
      sa_in.wok      = int'(req_entry_index) < TABLE_DEPTH;
      sa_in.conn     = req_adc_reading < thr_ff;
      sa_in.v        = req_adc_reading;
      sa_in.widx     = ADDR_W'(req_entry_index);
      sa_in.wval     = req_entry_value;
      sa_in.lo       = '0;
      sa_in.hi       = n_last;
   end

   attu_ram #(.WIDTH(ADC_W), .DEPTH(TABLE_DEPTH)) u_ram_first (
      .clock   (clock),
      .wr_en   (wr_now),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_addr ('0),
      .rd_data (rd_first)
   );

   attu_ram #(.WIDTH(ADC_W), .DEPTH(TABLE_DEPTH)) u_ram_last (
      .clock   (clock),
      .wr_en   (wr_now),
      .wr_addr (ADDR_W'(req_entry_index)),
      .wr_data (req_entry_value),
      .rd_addr (n_last),
      .rd_data (rd_last)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         sa_ff[0].valid <= 1'b0;
      end else begin
         sa_ff[0].valid <= sa_in.valid;
      end
      sa_ff[0].wr       <= sa_in.wr;
      sa_ff[0].wok      <= sa_in.wok;
      sa_ff[0].conn     <= sa_in.conn;
      sa_ff[0].v        <= sa_in.v;
      sa_ff[0].widx     <= sa_in.widx;
      sa_ff[0].wval     <= sa_in.wval;
      sa_ff[0].lo       <= sa_in.lo;
      sa_ff[0].hi       <= sa_in.hi;
      sa_ff[0].vlo      <= sa_in.vlo;
      sa_ff[0].vhi      <= sa_in.vhi;
      sa_ff[0].done     <= sa_in.done;
      sa_ff[0].pick     <= sa_in.pick;
      sa_ff[0].mid_pend <= sa_in.mid_pend;
      sa_ff[0].mid      <= sa_in.mid;
   end

   always_comb begin
      sa_cur[0]     = sa_ff[0];
      sa_cur[0].vlo = rd_first;
      sa_cur[0].vhi = rd_last;
   end

   // search steps
   for (genvar k = 0; k < SEARCH_STEPS; k++) begin : g_step
      search_type a_nxt;
      search_type b_nxt;
      logic [ADDR_W:0] span;

      if (k > 0) begin : g_cur
         assign sa_cur[k] = sa_ff[k];
      end

      always_comb begin
         a_nxt          = sa_cur[k];
         a_nxt.mid_pend = 1'b0;
         span           = {1'b0, sa_cur[k].hi} - {1'b0, sa_cur[k].lo};
         a_nxt.mid      = ADDR_W'(({1'b0, sa_cur[k].lo} + {1'b0, sa_cur[k].hi}) >> 1);
         if (sa_cur[k].valid && !sa_cur[k].wr && !sa_cur[k].done) begin
            if (span > (ADDR_W+1)'(1)) begin
               if (sa_cur[k].v <= sa_cur[k].vlo) begin
                  a_nxt.done = 1'b1;
                  a_nxt.pick = sa_cur[k].lo;
               end else if (sa_cur[k].v >= sa_cur[k].vhi) begin
                  a_nxt.done = 1'b1;
                  a_nxt.pick = sa_cur[k].hi;
               end else begin
                  a_nxt.mid_pend = 1'b1;
               end
            end else begin
               a_nxt.done = 1'b1;
               a_nxt.pick = sa_cur[k].lo;
            end
         end
      end

      attu_ram #(.WIDTH(ADC_W), .DEPTH(TABLE_DEPTH)) u_ram_step (
         .clock   (clock),
         .wr_en   (sa_cur[k].valid && sa_cur[k].wr && sa_cur[k].wok),
         .wr_addr (sa_cur[k].widx),
         .wr_data (sa_cur[k].wval),
         .rd_addr (a_nxt.mid),
         .rd_data (step_rd[k])
      );

      always_ff @(posedge clock) begin
         if (reset) begin
            sb_ff[k] <= '0;
         end else begin
            sb_ff[k] <= a_nxt;
         end
      end

      always_comb begin
         b_nxt = sb_ff[k];
         if (sb_ff[k].mid_pend) begin
            if (sb_ff[k].v <= step_rd[k]) begin
               b_nxt.hi  = sb_ff[k].mid;
               b_nxt.vhi = step_rd[k];
            end else begin
               b_nxt.lo  = sb_ff[k].mid;
               b_nxt.vlo = step_rd[k];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sa_ff[k+1] <= '0;
         end else begin
            sa_ff[k+1] <= b_nxt;
         end
      end
   end

   assign sa_cur[SEARCH_STEPS] = sa_ff[SEARCH_STEPS];

   // segment ends
   assign fin_pick_in = sa_cur[SEARCH_STEPS].done ? sa_cur[SEARCH_STEPS].pick
                                                  : sa_cur[SEARCH_STEPS].lo;

   attu_ram #(.WIDTH(ADC_W), .DEPTH(TABLE_DEPTH)) u_ram_a0 (
      .clock   (clock),
      .wr_en   (sa_cur[SEARCH_STEPS].valid && sa_cur[SEARCH_STEPS].wr &&
                sa_cur[SEARCH_STEPS].wok),
      .wr_addr (sa_cur[SEARCH_STEPS].widx),
      .wr_data (sa_cur[SEARCH_STEPS].wval),
      .rd_addr (fin_pick_in),
      .rd_data (rd_a0)
   );

   attu_ram #(.WIDTH(ADC_W), .DEPTH(TABLE_DEPTH)) u_ram_a1 (
      .clock   (clock),
      .wr_en   (sa_cur[SEARCH_STEPS].valid && sa_cur[SEARCH_STEPS].wr &&
                sa_cur[SEARCH_STEPS].wok),
      .wr_addr (sa_cur[SEARCH_STEPS].widx),
      .wr_data (sa_cur[SEARCH_STEPS].wval),
      .rd_addr (fin_pick_in + ADDR_W'(1)),
      .rd_data (rd_a1)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_valid_ff <= 1'b0;
      end else begin
         fin_valid_ff <= sa_cur[SEARCH_STEPS].valid && !sa_cur[SEARCH_STEPS].wr;
      end
      fin_conn_ff <= sa_cur[SEARCH_STEPS].conn;
      fin_v_ff    <= sa_cur[SEARCH_STEPS].v;
      fin_pick_ff <= fin_pick_in;
      fin_last_ff <= fin_pick_in == n_last;
   end

   // difference and scaling
   always_comb begin
      logic signed [ADC_W:0] diff;
      logic signed [ADC_W:0] den;
      logic [ADC_W-1:0]      dmag;
      logic [ADC_W-1:0]      nmag;
      diff = signed'({1'b0, fin_v_ff}) - signed'({1'b0, rd_a0});
      den  = signed'({1'b0, rd_a1}) - signed'({1'b0, rd_a0});
      nmag = diff[ADC_W] ? ADC_W'(-diff) : ADC_W'(diff);
      dmag = den[ADC_W] ? ADC_W'(-den) : ADC_W'(den);
      m_in        = '0;
      m_in.valid  = fin_valid_ff;
      m_in.conn   = fin_conn_ff;
      m_in.direct = fin_last_ff || (rd_a1 == rd_a0);
      m_in.neg    = diff[ADC_W] ^ den[ADC_W];
      m_in.idd    = IDD_W'(fin_pick_ff) * IDD_W'(deg_ff);
      m_in.num    = NUM_W'(nmag) * NUM_W'(deg_ff);
      m_in.den    = dmag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         m_ff <= '0;
      end else begin
         m_ff <= m_in;
      end
   end

   // restoring divide, one quotient bit per stage
   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      arith_type src;
      logic [ADC_W:0] shifted;

      if (j == 0) begin : g_src0
         assign src = m_ff;
      end else begin : g_srcn
         assign src = div_ff[j-1];
      end

      always_comb begin
         div_in[j] = src;
         shifted   = {src.rem, src.num[NUM_W-1]};
         div_in[j].num = {src.num[NUM_W-2:0], 1'b0};
         if (shifted >= {1'b0, src.den}) begin
            div_in[j].rem = ADC_W'(shifted - {1'b0, src.den});
            div_in[j].quo = {src.quo[NUM_W-2:0], 1'b1};
         end else begin
            div_in[j].rem = ADC_W'(shifted);
            div_in[j].quo = {src.quo[NUM_W-2:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            div_ff[j] <= '0;
         end else begin
            div_ff[j] <= div_in[j];
         end
      end
   end

   // offset and clamp
   always_comb begin
      logic signed [SUM_W-1:0] q_s;
      logic signed [SUM_W-1:0] sum_s;
      q_s = signed'(SUM_W'(div_ff[DIV_STEPS-1].quo));
      if (div_ff[DIV_STEPS-1].neg) begin
         q_s = -q_s;
      end
      if (div_ff[DIV_STEPS-1].direct) begin
         q_s = '0;
      end
      sum_s = q_s + signed'(SUM_W'(div_ff[DIV_STEPS-1].idd)) + SUM_W'(amb_ff);
      if (!div_ff[DIV_STEPS-1].conn) begin
         out_temp_in = '0;
      end else if (sum_s < TEMP_MIN) begin
         out_temp_in = TEMP_W'(TEMP_MIN);
      end else if (sum_s > TEMP_MAX) begin
         out_temp_in = TEMP_W'(TEMP_MAX);
      end else begin
         out_temp_in = TEMP_W'(sum_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= div_ff[DIV_STEPS-1].valid;
      end
      out_conn_ff <= div_ff[DIV_STEPS-1].conn;
      out_temp_ff <= out_temp_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_connected   = out_conn_ff;
   assign rsp_temperature = out_temp_ff;

endmodule
`default_nettype wire

/* design/attu_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
module attu_ram #(
   parameter int WIDTH = 10,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/attu_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
`include "adc_to_temperature_table_interp_unit_assert.svh"
module attu_checker
   import attu_pkg::*;
(
   input logic                     clock,
   input logic                     reset,
   input logic                     start,
   input logic                     busy,
   input logic                     req_mode,
   input logic                     rsp_valid,
   input logic                     rsp_connected,
   input logic signed [TEMP_W-1:0] rsp_temperature
);

   `ATTU_ASSERT_NEXT(a_busy_clears, !reset, !busy)
   `ATTU_ASSERT_IMP(a_disconnected_zero, rsp_valid && !rsp_connected, rsp_temperature == '0)
   `ATTU_ASSERT_DELAY(a_convert_latency, start && !busy && !req_mode, LATENCY, rsp_valid)
   `ATTU_ASSERT_IMP(a_result_source, rsp_valid, $past(start && !busy && !req_mode, LATENCY))

endmodule

bind adc_to_temperature_table_interp_unit attu_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_mode        (req_mode),
   .rsp_valid       (rsp_valid),
   .rsp_connected   (rsp_connected),
   .rsp_temperature (rsp_temperature)
);
`default_nettype wire
